@@ rtl/trw_pkg.sv @@
// Package for the trigger word stream decoder: constants, result type, bit count.
`timescale 1ns / 1ps

package trw_pkg;

    // Number of trigger bits and channels in use.
    localparam int TriggerBits = 32;
    localparam int Channels    = 64;

    localparam logic [31:0] TrigUsedMask = 32'hFFFF_FFFF >> (32 - TriggerBits);
    localparam logic [63:0] ChanUsedMask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - Channels);

    // Configuration register indexes.
    localparam logic [1:0] REG_SEPARATOR  = 2'd0;
    localparam logic [1:0] REG_WINDOW_MIN = 2'd1;
    localparam logic [1:0] REG_WINDOW_MAX = 2'd2;

    // Result kinds.
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [15:0] TotalMax = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] trigger_mask;
        logic [31:0] trigger_time;
        logic [5:0]  bits_set;
        logic [15:0] trigger_total;
        logic [63:0] channel_hits;
        logic [63:0] channel_in_window;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [31:0]        separator;
        logic signed [63:0] window_min;
        logic signed [63:0] window_max;
    } cfg_t;

    function automatic logic [5:0] count_ones(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            n = n + {5'd0, v[i]};
        end
        return n;
    endfunction

endpackage

@@ rtl/trw_core.sv @@
// Decoding state and per-word result formation for the trigger word stream decoder.
`timescale 1ns / 1ps

module trw_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [31:0]         word,
    input  logic                last_word,
    input  trw_pkg::cfg_t       cfg,
    output logic                rec_valid,
    output trw_pkg::result_t    rec,
    output logic                sum_valid,
    output trw_pkg::result_t    sum
);

    logic        phase_reg, phase_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] held_reg [3];
    logic [63:0] hit_reg, hit_next;
    logic [63:0] win_reg, win_next;
    logic [15:0] total_reg, total_next;

    logic [31:0]        masked;
    logic [5:0]         nbits;
    logic [16:0]        total_sum;
    logic [63:0]        chmask;
    logic signed [63:0] ch_time;
    logic               in_window;
    logic               is_separator;

    always_comb
    begin
        masked       = held_reg[0] & trw_pkg::TrigUsedMask;
        nbits        = trw_pkg::count_ones(masked);
        total_sum    = {1'b0, total_reg} + {11'd0, nbits};
        is_separator = (held_reg[0] == cfg.separator) && (word == cfg.separator);
        chmask       = {held_reg[1], held_reg[0]} & trw_pkg::ChanUsedMask;
        ch_time      = {word, held_reg[2]};
        in_window    = (ch_time >= cfg.window_min) && (ch_time <= cfg.window_max);

        phase_next = phase_reg;
        pos_next   = pos_reg;
        hit_next   = hit_reg;
        win_next   = win_reg;
        total_next = total_reg;
        rec_valid  = 1'b0;

        if (!phase_reg)
        begin
            if (pos_reg == 2'd0)
            begin
                pos_next = 2'd1;
            end
            else
            begin
                pos_next = 2'd0;
                if (is_separator)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    rec_valid  = 1'b1;
                    total_next = total_sum[16] ? trw_pkg::TotalMax : total_sum[15:0];
                end
            end
        end
        else
        begin
            if (pos_reg != 2'd3)
            begin
                pos_next = pos_reg + 2'd1;
            end
            else
            begin
                pos_next = 2'd0;
                hit_next = hit_reg | chmask;
                if (in_window)
                begin
                    win_next = win_reg | chmask;
                end
            end
        end

        rec.kind              = trw_pkg::KIND_RECORD;
        rec.trigger_mask      = masked;
        rec.trigger_time      = word;
        rec.bits_set          = nbits;
        rec.trigger_total     = total_next;
        rec.channel_hits      = 64'd0;
        rec.channel_in_window = 64'd0;
        rec.last_result       = 1'b0;

        sum_valid             = last_word;
        sum.kind              = trw_pkg::KIND_SUMMARY;
        sum.trigger_mask      = 32'd0;
        sum.trigger_time      = 32'd0;
        sum.bits_set          = 6'd0;
        sum.trigger_total     = total_next;
        sum.channel_hits      = hit_next;
        sum.channel_in_window = win_next;
        sum.last_result       = 1'b1;
    end

    // The held words carry no reset; each is written before it is read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!phase_reg)
            begin
                if (pos_reg == 2'd0)
                begin
                    held_reg[0] <= word;
                end
            end
            else if (pos_reg != 2'd3)
            begin
                held_reg[pos_reg] <= word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            pos_reg   <= 2'd0;
            hit_reg   <= 64'd0;
            win_reg   <= 64'd0;
            total_reg <= 16'd0;
        end
        else if (accept)
        begin
            if (last_word)
            begin
                phase_reg <= 1'b0;
                pos_reg   <= 2'd0;
                hit_reg   <= 64'd0;
                win_reg   <= 64'd0;
                total_reg <= 16'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                hit_reg   <= hit_next;
                win_reg   <= win_next;
                total_reg <= total_next;
            end
        end
    end

endmodule

@@ rtl/trw_ofifo.sv @@
// Four-entry result queue taking up to two results per cycle and giving one.
`timescale 1ns / 1ps

module trw_ofifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push0,
    input  trw_pkg::result_t    data0,
    input  logic                push1,
    input  trw_pkg::result_t    data1,
    output logic                room,
    output logic                head_valid,
    output trw_pkg::result_t    head,
    input  logic                pop
);

    trw_pkg::result_t mem_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic [1:0] wr_second;
    logic       do_pop;

    assign room       = (count_reg <= 3'd2);
    assign head_valid = (count_reg != 3'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    assign wr_second  = wr_ptr_reg + {1'b0, push0};

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wr_ptr_reg] <= data0;
        end
        if (push1)
        begin
            mem_reg[wr_second] <= data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + {1'b0, push0} + {1'b0, push1};
            rd_ptr_reg <= rd_ptr_reg + {1'b0, do_pop};
            count_reg  <= count_reg + {2'd0, push0} + {2'd0, push1} - {2'd0, do_pop};
        end
    end

endmodule

@@ rtl/trigger_word_stream_decoder.sv @@
// Top level of the trigger word stream decoder: ports, configuration registers, wiring.
`timescale 1ns / 1ps
// A result enters the result queue when the word that causes it is transferred.
// Throughput: one word per cycle; a word that ends the event with a trigger record
// yields two results, and the four-entry result queue drains them one per cycle while
// out_stall is low. The input stalls only while the queue lacks room for two results.
// Reset clears the event state and the queue and loads the separator as zero and the
// coincidence window as -16 to 16; no clearing pass is needed.

module trigger_word_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] word,
    input  logic        last_word,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [31:0] trigger_mask,
    output logic [31:0] trigger_time,
    output logic [5:0]  bits_set,
    output logic [15:0] trigger_total,
    output logic [63:0] channel_hits,
    output logic [63:0] channel_in_window,
    output logic        last_result,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Configuration registers. Writes are always taken; an index past the
    // window maximum is simply dropped.
    logic [31:0]        sep_reg;
    logic signed [63:0] wmin_reg;
    logic signed [63:0] wmax_reg;
    trw_pkg::cfg_t      cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg  <= 32'd0;
            wmin_reg <= -64'sd16;
            wmax_reg <= 64'sd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                trw_pkg::REG_SEPARATOR:  sep_reg  <= cfg_data[31:0];
                trw_pkg::REG_WINDOW_MIN: wmin_reg <= cfg_data;
                trw_pkg::REG_WINDOW_MAX: wmax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.separator  = sep_reg;
    assign cfg.window_min = wmin_reg;
    assign cfg.window_max = wmax_reg;

    // A word is transferred whenever the result queue can hold the two
    // results it may cause, so the decoder never has to hold a result back.
    logic             room;
    logic             accept;
    logic             rec_valid;
    logic             sum_valid;
    trw_pkg::result_t rec;
    trw_pkg::result_t sum;
    trw_pkg::result_t head;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    trw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (word),
        .last_word (last_word),
        .cfg       (cfg),
        .rec_valid (rec_valid),
        .rec       (rec),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    // The trigger record, when there is one, goes into the queue ahead of the
    // end-of-event summary, matching the order in which they are produced.
    trw_ofifo u_ofifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (accept && rec_valid),
        .data0      (rec),
        .push1      (accept && sum_valid),
        .data1      (sum),
        .room       (room),
        .head_valid (out_valid),
        .head       (head),
        .pop        (!out_stall)
    );

    assign kind              = head.kind;
    assign trigger_mask      = head.trigger_mask;
    assign trigger_time      = head.trigger_time;
    assign bits_set          = head.bits_set;
    assign trigger_total     = head.trigger_total;
    assign channel_hits      = head.channel_hits;
    assign channel_in_window = head.channel_in_window;
    assign last_result       = head.last_result;

endmodule

@@ sim/trigger_word_stream_decoder_test.sv @@
// Self-checking testbench for the trigger word stream decoder with a built-in event predictor.
`timescale 1ns / 1ps

module trigger_word_stream_decoder_test;

    // Index past the end of the register list; a write to it must change nothing.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Generous cycle budget. The slowest correct run is under a thousand words and
    // at most twice as many results, each stalled a few cycles, plus the long hold-offs.
    localparam int CycleLimit = 400000;

    // Cycles allowed after the last result before the block counts as idle.
    localparam int SettleCycles = 4;

    typedef struct packed {
        logic [31:0] data;
        logic        last;
    } word_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] word = 32'd0;
    logic        last_word = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [31:0] trigger_mask;
    logic [31:0] trigger_time;
    logic [5:0]  bits_set;
    logic [15:0] trigger_total;
    logic [63:0] channel_hits;
    logic [63:0] channel_in_window;
    logic        last_result;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [63:0] cfg_data = 64'd0;

    trigger_word_stream_decoder DUT (.*);

    // Words waiting to be offered, and results the predictor says must come out.
    word_item_t         word_queue[$];
    trw_pkg::result_t   awaited_results[$];

    int words_queued = 0;   // words placed in word_queue so far
    int words_sent   = 0;   // words transferred into the block so far
    int random_words = 0;   // words produced by the random event generator
    int errors       = 0;
    int cycle_count  = 0;

    // Configuration as the block should hold it.
    logic [31:0]        cfg_sep  = 32'd0;
    logic signed [63:0] cfg_wmin = -64'sd16;
    logic signed [63:0] cfg_wmax = 64'sd16;

    // Event state of the predictor.
    logic        in_channel_part = 1'b0;
    logic [1:0]  word_pos = 2'd0;
    logic [31:0] held[3];
    logic [63:0] hits_acc = 64'd0;
    logic [63:0] window_acc = 64'd0;
    logic [15:0] trig_total = 16'd0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Predicts the results of one transferred word and updates the event state.
    // The first part of an event is (mask, time) pairs; a pair of two separator
    // words switches to 4-word channel blocks. The last word always ends with
    // a summary, after which the event state starts over.
    function automatic void decode_word(input logic [31:0] w, input logic lw);
        trw_pkg::result_t   r;
        logic [31:0]        m;
        logic [5:0]         b;
        logic [16:0]        sum;
        logic [63:0]        chan_mask;
        logic signed [63:0] chan_time;
        if (!in_channel_part)
        begin
            if (word_pos == 2'd0)
            begin
                held[0] = w;
                word_pos = 2'd1;
            end
            else
            begin
                word_pos = 2'd0;
                if (held[0] == cfg_sep && w == cfg_sep)
                begin
                    in_channel_part = 1'b1;
                end
                else
                begin
                    m = held[0] & trw_pkg::TrigUsedMask;
                    b = 6'($countones(m));
                    sum = {1'b0, trig_total} + {11'd0, b};
                    trig_total = sum[16] ? trw_pkg::TotalMax : sum[15:0];
                    r = '0;
                    r.kind = trw_pkg::KIND_RECORD;
                    r.trigger_mask = m;
                    r.trigger_time = w;
                    r.bits_set = b;
                    r.trigger_total = trig_total;
                    awaited_results.insert(awaited_results.size(), r);
                end
            end
        end
        else if (word_pos != 2'd3)
        begin
            held[word_pos] = w;
            word_pos = word_pos + 2'd1;
        end
        else
        begin
            // The time's high half is the word in hand, so a block is complete here.
            chan_mask = {held[1], held[0]} & trw_pkg::ChanUsedMask;
            chan_time = {w, held[2]};
            hits_acc = hits_acc | chan_mask;
            if (chan_time >= cfg_wmin && chan_time <= cfg_wmax)
            begin
                window_acc = window_acc | chan_mask;
            end
            word_pos = 2'd0;
        end

        if (lw)
        begin
            r = '0;
            r.kind = trw_pkg::KIND_SUMMARY;
            r.trigger_total = trig_total;
            r.channel_hits = hits_acc;
            r.channel_in_window = window_acc;
            r.last_result = 1'b1;
            awaited_results.insert(awaited_results.size(), r);
            in_channel_part = 1'b0;
            word_pos = 2'd0;
            hits_acc = 64'd0;
            window_acc = 64'd0;
            trig_total = 16'd0;
        end
    endfunction

    // Sender. It offers words from word_queue in bursts of random length with
    // random gaps between them; now and then a long burst runs with no gap at all.
    // A word stays on the port until it is transferred.
    int         burst_left = 1;
    int         gap_left = 0;
    word_item_t next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            words_sent <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_word(word, last_word);
                words_sent <= words_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_queue.size() != 0)
                begin
                    next_item = word_queue.pop_front();
                    word <= next_item.data;
                    last_word <= next_item.last;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = 40;
                            gap_left = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left = $urandom_range(0, 6);
                        end
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. A free-running cycle counter re-picks the stall pattern from never, light,
    // heavy and alternating. After 100 transferred words, and every 300 after that, it
    // also holds off without a break, long enough for the result queue to fill and the
    // input side to stall while the sender keeps offering words.
    int stall_mode = 0;
    int mode_cycles = 0;
    int long_hold = 0;
    int next_long_hold = 100;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            mode_cycles++;
            if (mode_cycles == 64)
            begin
                mode_cycles = 0;
                stall_mode = $urandom_range(0, 3);
            end
            if (long_hold > 0)
            begin
                long_hold--;
                out_stall <= 1'b1;
            end
            else if (words_sent >= next_long_hold)
            begin
                long_hold = 150;
                next_long_hold += 300;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] expected,
                               input logic [63:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
            errors++;
        end
    endtask

    // Checks each transferred result against the oldest prediction.
    trw_pkg::result_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %b total %h",
                         $time, kind, trigger_total);
                errors++;
            end
            else
            begin
                oldest = awaited_results.pop_front();
                check_field("kind", 64'(oldest.kind), 64'(kind));
                check_field("trigger_mask", 64'(oldest.trigger_mask), 64'(trigger_mask));
                check_field("trigger_time", 64'(oldest.trigger_time), 64'(trigger_time));
                check_field("bits_set", 64'(oldest.bits_set), 64'(bits_set));
                check_field("trigger_total", 64'(oldest.trigger_total), 64'(trigger_total));
                check_field("channel_hits", oldest.channel_hits, channel_hits);
                check_field("channel_in_window", oldest.channel_in_window, channel_in_window);
                check_field("last_result", 64'(oldest.last_result), 64'(last_result));
            end
        end
    end

    // Watchdog: a run that never drains ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("trigger_word_stream_decoder verification failed");
            $finish;
        end
    end

    task automatic push_item(input logic [31:0] data, input logic last);
        word_item_t it;
        it.data = data;
        it.last = last;
        word_queue.insert(word_queue.size(), it);
        words_queued++;
    endtask

    // Queues one channel block: mask low, mask high, time low, time high.
    task automatic push_block(input logic [63:0] mask, input logic [63:0] when,
                              input logic last);
        push_item(mask[31:0], 1'b0);
        push_item(mask[63:32], 1'b0);
        push_item(when[31:0], 1'b0);
        push_item(when[63:32], last);
    endtask

    // Waits until every queued word has been transferred and every predicted
    // result has arrived, then lets the block settle. The sender has nothing
    // to offer while this runs, so it also serves as the full pause in sending.
    task automatic wait_idle();
        @(posedge clk);
        while (words_sent != words_queued || awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            trw_pkg::REG_SEPARATOR:  cfg_sep = val[31:0];
            trw_pkg::REG_WINDOW_MIN: cfg_wmin = val;
            trw_pkg::REG_WINDOW_MAX: cfg_wmax = val;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_trig_mask();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return 32'd1 << $urandom_range(0, 31);
            3: return cfg_sep;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [63:0] pick_chan_mask();
        case ($urandom_range(0, 5))
            0: return 64'hFFFF_FFFF_FFFF_FFFF;
            1: return 64'd0;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Channel times cluster on the window edges and around zero so that both
    // sides of each bound are hit often.
    function automatic logic [63:0] pick_time();
        case ($urandom_range(0, 6))
            0: return cfg_wmin;
            1: return cfg_wmax;
            2: return cfg_wmin - 64'sd1;
            3: return cfg_wmax + 64'sd1;
            4: return {$urandom(), $urandom()};
            default: return 64'($signed(33'($urandom_range(0, 64))) - 33'sd32);
        endcase
    endfunction

    // Builds one random event. Most are well formed: trigger pairs, a separator
    // pair, channel blocks and sometimes a partial block at the end. The rest
    // are trigger-only events and noise that sprinkles separator words around.
    task automatic queue_event();
        logic [31:0] words[$];
        int          shape;
        int          count;
        int          tail;
        logic [63:0] mask;
        logic [63:0] when;
        shape = $urandom_range(0, 6);
        tail = 0;
        if (shape <= 5)
        begin
            count = $urandom_range(0, 5);
            for (int i = 0; i < count; i++)
            begin
                words.insert(words.size(), pick_trig_mask());
                words.insert(words.size(), $urandom());
            end
        end
        if (shape <= 4)
        begin
            words.insert(words.size(), cfg_sep);
            words.insert(words.size(), cfg_sep);
            count = $urandom_range(0, 4);
            for (int i = 0; i < count; i++)
            begin
                mask = pick_chan_mask();
                when = pick_time();
                words.insert(words.size(), mask[31:0]);
                words.insert(words.size(), mask[63:32]);
                words.insert(words.size(), when[31:0]);
                words.insert(words.size(), when[63:32]);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                tail = $urandom_range(1, 3);
            end
        end
        else if (shape == 5)
        begin
            tail = $urandom_range(0, 1);
        end
        else
        begin
            tail = $urandom_range(1, 9);
        end
        for (int i = 0; i < tail; i++)
        begin
            words.insert(words.size(),
                         ($urandom_range(0, 2) == 0) ? cfg_sep : 32'($urandom()));
        end
        if (words.size() == 0)
        begin
            words.insert(words.size(), $urandom());
        end
        foreach (words[i])
        begin
            push_item(words[i], i == words.size() - 1);
        end
        random_words += words.size();
    endtask

    task automatic random_phase(input int amount);
        int target;
        target = random_words + amount;
        while (random_words < target)
        begin
            queue_event();
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events under the reset configuration (separator zero,
        // window -16 to 16). No separator pair, full and empty masks; the
        // empty-mask pair also has a mask equal to the separator but a time
        // that is not. The last word closes a pair, giving two results.
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'h1234_5678, 1'b1);
        // A one-word event: nothing but the summary.
        push_item(32'hA5A5_A5A5, 1'b1);
        // One pair followed by a stray word that ends the event.
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'h0000_0007, 1'b1);
        // Channel part: times on the low edge, past the high edge and past the
        // low edge, then a partial block.
        push_item(32'd0, 1'b0);
        push_item(32'd0, 1'b0);
        push_block(64'hFFFF_FFFF_FFFF_FFFF, -64'sd16, 1'b0);
        push_block(64'h8000_0000_0000_0000, 64'sd17, 1'b0);
        push_block(64'h0000_0000_0000_0001, -64'sd17, 1'b0);
        push_item(32'h0000_0003, 1'b1);
        // The separator pair itself ends the event.
        push_item(32'd0, 1'b0);
        push_item(32'd0, 1'b1);
        wait_idle();
        random_phase(90);

        // Widest possible window: every channel time is coincident.
        write_reg(trw_pkg::REG_SEPARATOR, {32'd0, 32'($urandom())});
        write_reg(trw_pkg::REG_WINDOW_MIN, 64'h8000_0000_0000_0000);
        write_reg(trw_pkg::REG_WINDOW_MAX, 64'h7FFF_FFFF_FFFF_FFFF);
        push_item(cfg_sep, 1'b0);
        push_item(cfg_sep, 1'b0);
        push_block(64'h0000_0000_F000_0000, 64'h8000_0000_0000_0000, 1'b0);
        push_block(64'h0F00_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        wait_idle();
        random_phase(90);

        // Inverted window: no channel time can be coincident.
        write_reg(trw_pkg::REG_SEPARATOR, 64'h0000_0000_FFFF_FFFF);
        write_reg(trw_pkg::REG_WINDOW_MIN, 64'sd5);
        write_reg(trw_pkg::REG_WINDOW_MAX, -64'sd5);
        random_phase(90);

        // A write past the register list must leave the configuration alone.
        write_reg(REG_UNUSED, {$urandom(), $urandom()});
        write_reg(trw_pkg::REG_SEPARATOR, 64'd0);
        write_reg(trw_pkg::REG_WINDOW_MIN, 64'sd0);
        write_reg(trw_pkg::REG_WINDOW_MAX, 64'sd0);
        random_phase(90);

        // A long trigger-only event: 40 full-mask pairs build up a large total.
        // The time words are never zero, so no pair matches the separator.
        for (int i = 0; i < 40; i++)
        begin
            push_item(32'hFFFF_FFFF, 1'b0);
            push_item(32'(i + 1), i == 39);
        end
        wait_idle();
        random_phase(40);

        // A random separator and a narrow random window for the rest.
        write_reg(trw_pkg::REG_SEPARATOR, {32'd0, 32'($urandom())});
        write_reg(trw_pkg::REG_WINDOW_MIN,
                  64'($signed(33'($urandom_range(0, 40))) - 33'sd40));
        write_reg(trw_pkg::REG_WINDOW_MAX, 64'($urandom_range(0, 40)));
        random_phase(100);

        if (errors == 0 && awaited_results.size() == 0)
        begin
            $display("trigger_word_stream_decoder verification clean");
        end
        else
        begin
            $display("trigger_word_stream_decoder verification failed");
        end
        $finish;
    end

endmodule
